// ----- hdl/spnc_pkg.sv -----
// ---------------------------------------------------------------------------
// spnc_pkg
// Shared types and constants for the sorted path name checker.
// ---------------------------------------------------------------------------
package spnc_pkg;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;  // 'z'
  localparam logic [BYTE_W-1:0] CH_DIG_0 = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_DIG_9 = 8'h39;  // '9'
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [BYTE_W-1:0] CH_HYPH  = 8'h2D;  // '-'

  localparam logic [1:0] SEG_LEN_MAX = 2'd3;

  // String compare progress against the previous name
  typedef enum logic [1:0] {
    ORD_EQUAL,
    ORD_LESS,
    ORD_GREATER,
    ORD_DONE
  } order_t;

  function automatic logic char_allowed(input logic [BYTE_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
           c == CH_UNDER || c == CH_HYPH || c == CH_DOT;
  endfunction

endpackage

// ----- hdl/spnc_in_if.sv -----
// ---------------------------------------------------------------------------
// spnc_in_if
// Name byte channel: one byte of a fixed-length name per item.
// ---------------------------------------------------------------------------
interface spnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [spnc_pkg::BYTE_W-1:0] name_byte;
  logic                        list_start;

  modport source (output valid, output name_byte, output list_start, input ready);
  modport sink   (input valid, input name_byte, input list_start, output ready);
endinterface

// ----- hdl/spnc_out_if.sv -----
// ---------------------------------------------------------------------------
// spnc_out_if
// Result channel: one verdict item per name.
// ---------------------------------------------------------------------------
interface spnc_out_if;
  logic valid;
  logic ready;
  logic name_valid;
  logic ascending;

  modport source (output valid, output name_valid, output ascending, input ready);
  modport sink   (input valid, input name_valid, input ascending, output ready);
endinterface

// ----- hdl/sorted_path_name_checker_core.sv -----
// ---------------------------------------------------------------------------
// sorted_path_name_checker_core
// Streams fixed-length, zero-padded path names and reports legality and order.
// ---------------------------------------------------------------------------
// Names arrive one byte per item, NAME_BYTES items per name, first byte first.
// One byte is taken every clock cycle unless the input is stalled; the last byte
// of a name is registered in the check stage, then loads one result item holding
// name_valid (terminator present and not first, zero padding after it, every
// slash-separated segment non-empty, not "." or "..", characters limited to
// a-z 0-9 _ - .) and ascending (name strictly greater than the previous name
// in unsigned string order, or list_start set on the last byte). Throughput
// is set by the single read-first port of the previous-name store, which is
// read and rewritten at the same position on every accepted byte. The store
// comes out of reset reading as all zero through per-entry written flags, so
// no clearing pass is needed and the first byte may enter right after reset.
// Input is stalled only while a finished result waits in the output register
// and the next name's last byte is ready to produce another.
// ---------------------------------------------------------------------------
module sorted_path_name_checker_core #(
  parameter int NAME_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  spnc_in_if.sink    names,
  spnc_out_if.source results
);
  import spnc_pkg::*;

  localparam int             POS_W    = $clog2(NAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NAME_BYTES - 1);

  // ---- byte position and previous-name store --------------------------------
  logic [POS_W-1:0]       pos;
  logic [NAME_BYTES-1:0]  written;         // entry holds a byte since reset
  logic [BYTE_W-1:0]      prev_mem [NAME_BYTES];
  logic [BYTE_W-1:0]      prev_rd;

  logic in_acc;
  logic in_ready;

  // ---- check stage (one byte in flight) --------------------------------------
  logic              s2_valid;
  logic [BYTE_W-1:0] s2_byte;
  logic              s2_start;
  logic              s2_first;
  logic              s2_last;
  logic              s2_prev_ok;
  logic              s2_adv;

  // ---- per-name state ---------------------------------------------------------
  logic       term_seen,  term_seen_next;
  logic [1:0] seg_len,    seg_len_next;
  logic [1:0] seg_dots,   seg_dots_next;
  logic       name_err,   name_err_next;
  order_t     order,      order_next;

  // ---- result register --------------------------------------------------------
  logic out_valid, out_valid_next;
  logic out_name_valid, out_asc;
  logic res_name_valid, res_asc;

  // updated state before end-of-name clear
  logic       term_upd;
  logic [1:0] seg_len_upd;
  logic [1:0] seg_dots_upd;
  logic       err_upd;
  order_t     order_upd;
  logic [BYTE_W-1:0] prev_byte;
  logic       seg_bad;

  // Check stage frees when its byte is not a name end, or the result slot
  // is empty or draining this cycle.
  assign s2_adv   = s2_valid && !(s2_last && out_valid && !results.ready);
  assign in_ready = !s2_valid || s2_adv;
  assign in_acc   = names.valid && in_ready;

  assign names.ready        = in_ready;
  assign results.valid      = out_valid;
  assign results.name_valid = out_name_valid;
  assign results.ascending  = out_asc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_acc) begin
      pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (in_acc) begin
      written[pos] <= 1'b1;
    end
  end

  // Read-first: the old byte at this position is what the new byte compares to
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_rd       <= prev_mem[pos];
      prev_mem[pos] <= names.name_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_acc) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_byte    <= names.name_byte;
      s2_start   <= names.list_start;
      s2_first   <= (pos == '0);
      s2_last    <= (pos == LAST_POS);
      s2_prev_ok <= written[pos];
    end
  end

  // ---- byte checks and compare ----------------------------------------------
  always_comb begin
    prev_byte = s2_prev_ok ? prev_rd : CH_NUL;
    seg_bad   = (seg_len == 2'd0) ||
                (seg_len == 2'd1 && seg_dots[0]) ||
                (seg_len == 2'd2 && seg_dots == 2'b11);

    term_upd     = term_seen;
    seg_len_upd  = seg_len;
    seg_dots_upd = seg_dots;
    err_upd      = name_err;
    order_upd    = order;

    if (term_seen) begin
      if (s2_byte != CH_NUL) err_upd = 1'b1;
    end else if (s2_byte == CH_NUL) begin
      if (s2_first || seg_bad) err_upd = 1'b1;
      term_upd = 1'b1;
    end else if (s2_byte == CH_SLASH) begin
      if (seg_bad) err_upd = 1'b1;
      seg_len_upd  = 2'd0;
      seg_dots_upd = 2'b00;
    end else begin
      if (!char_allowed(s2_byte)) err_upd = 1'b1;
      if (s2_byte == CH_DOT) begin
        if (seg_len == 2'd0) begin
          seg_dots_upd[0] = 1'b1;
        end else if (seg_len == 2'd1) begin
          seg_dots_upd[1] = 1'b1;
        end
      end
      if (seg_len != SEG_LEN_MAX) seg_len_upd = seg_len + 2'd1;
    end

    // first difference, or a shared terminator, settles the order
    if (order == ORD_EQUAL) begin
      if (s2_byte < prev_byte) begin
        order_upd = ORD_LESS;
      end else if (s2_byte > prev_byte) begin
        order_upd = ORD_GREATER;
      end else if (s2_byte == CH_NUL) begin
        order_upd = ORD_DONE;
      end
    end

    res_name_valid = !err_upd && term_upd;
    res_asc        = s2_start || (order_upd == ORD_GREATER);
  end

  always_comb begin
    term_seen_next = term_seen;
    seg_len_next   = seg_len;
    seg_dots_next  = seg_dots;
    name_err_next  = name_err;
    order_next     = order;
    out_valid_next = out_valid && !results.ready;

    if (s2_adv) begin
      if (s2_last) begin
        term_seen_next = 1'b0;
        seg_len_next   = 2'd0;
        seg_dots_next  = 2'b00;
        name_err_next  = 1'b0;
        order_next     = ORD_EQUAL;
        out_valid_next = 1'b1;
      end else begin
        term_seen_next = term_upd;
        seg_len_next   = seg_len_upd;
        seg_dots_next  = seg_dots_upd;
        name_err_next  = err_upd;
        order_next     = order_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_seen <= 1'b0;
      seg_len   <= 2'd0;
      seg_dots  <= 2'b00;
      name_err  <= 1'b0;
      order     <= ORD_EQUAL;
      out_valid <= 1'b0;
    end else begin
      term_seen <= term_seen_next;
      seg_len   <= seg_len_next;
      seg_dots  <= seg_dots_next;
      name_err  <= name_err_next;
      order     <= order_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last) begin
      out_name_valid <= res_name_valid;
      out_asc        <= res_asc;
    end
  end

`ifndef SYNTH
  // A name end leaving the check stage always loads a result
  a_end_loads_result: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_last |=> out_valid)
    else $error("name end did not produce a result");

  // Per-name state starts clean after each result
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_last |=> !term_seen && seg_len == 2'd0 && seg_dots == 2'b00 &&
                          !name_err && order == ORD_EQUAL)
    else $error("name state not cleared after result");

  // Input only stalls behind a waiting result with another name end pending
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s2_valid && s2_last && out_valid && !results.ready)
    else $error("input stalled without cause");

  // Position returns to zero exactly when a name end is accepted
  a_pos_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && pos == LAST_POS |=> pos == '0 && s2_last)
    else $error("byte position did not wrap at name end");
`endif

endmodule

// ----- dv/spnc_verdict_checker.sv -----
// ---------------------------------------------------------------------------
// spnc_verdict_checker
// Watches both channels of the name checker, works out the verdict of each
// name from the accepted bytes and compares it with the result items.
// ---------------------------------------------------------------------------
module spnc_verdict_checker #(
  parameter int NAME_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  spnc_in_if   names,
  spnc_out_if  results,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spnc_pkg::*;

  typedef struct packed {
    logic name_valid;
    logic ascending;
  } verdict_t;

  verdict_t             expected_verdicts[$];
  logic [BYTE_W-1:0]    prior_name [NAME_BYTES];
  int                   byte_pos;
  logic                 term_seen;
  logic [1:0]           seg_len;
  logic [1:0]           dot_marks;
  logic                 name_bad;
  order_t               order;
  int                   fail_count;

  function automatic logic char_legal(input logic [BYTE_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
           c == CH_UNDER || c == CH_HYPH || c == CH_DOT;
  endfunction

  // empty, "." or ".."
  function automatic logic segment_illegal(input logic [1:0] len, input logic [1:0] marks);
    return len == 2'd0 || (len == 2'd1 && marks[0]) || (len == 2'd2 && marks == 2'b11);
  endfunction

  task automatic name_restart();
    byte_pos  = 0;
    term_seen = 1'b0;
    seg_len   = 2'd0;
    dot_marks = 2'd0;
    name_bad  = 1'b0;
    order     = ORD_EQUAL;
  endtask

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic take_byte(input logic [BYTE_W-1:0] b, input logic ls);
    int       pos;
    verdict_t v;
    pos = byte_pos;
    if (pos >= NAME_BYTES) pos = 0;

    if (term_seen) begin
      if (b != CH_NUL) name_bad = 1'b1;
    end else if (b == CH_NUL) begin
      if (pos == 0 || segment_illegal(seg_len, dot_marks)) name_bad = 1'b1;
      term_seen = 1'b1;
    end else if (b == CH_SLASH) begin
      if (segment_illegal(seg_len, dot_marks)) name_bad = 1'b1;
      seg_len   = 2'd0;
      dot_marks = 2'd0;
    end else begin
      if (!char_legal(b)) name_bad = 1'b1;
      if (b == CH_DOT) begin
        if (seg_len == 2'd0) dot_marks[0] = 1'b1;
        else if (seg_len == 2'd1) dot_marks[1] = 1'b1;
      end
      if (seg_len != SEG_LEN_MAX) seg_len = seg_len + 2'd1;
    end

    // string order stops at the first difference or a shared terminator
    if (order == ORD_EQUAL) begin
      if (b < prior_name[pos]) order = ORD_LESS;
      else if (b > prior_name[pos]) order = ORD_GREATER;
      else if (b == CH_NUL) order = ORD_DONE;
    end
    prior_name[pos] = b;

    if (pos + 1 < NAME_BYTES) begin
      byte_pos = pos + 1;
    end else begin
      v.name_valid = !name_bad && term_seen;
      v.ascending  = ls || order == ORD_GREATER;
      expected_verdicts.push_back(v);
      name_restart();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      name_restart();
      foreach (prior_name[i]) prior_name[i] = CH_NUL;
      expected_verdicts.delete();
    end else begin
      if (names.valid && names.ready) take_byte(names.name_byte, names.list_start);
      if (results.valid && results.ready) begin
        if (expected_verdicts.size() == 0) begin
          report("result item with no name pending");
        end else begin
          want = expected_verdicts.pop_front();
          if (results.name_valid !== want.name_valid)
            report($sformatf("name_valid got %b expected %b", results.name_valid,
                             want.name_valid));
          if (results.ascending !== want.ascending)
            report($sformatf("ascending got %b expected %b", results.ascending,
                             want.ascending));
        end
      end
    end
    mismatches <= fail_count;
    pending    <= expected_verdicts.size();
  end

endmodule

// ----- dv/sorted_path_name_checker_core_tb.sv -----
// ---------------------------------------------------------------------------
// sorted_path_name_checker_core_tb
// Streams directed and random 64-byte names through the checker core with
// random sender gaps and receiver stalls; a side checker scores each verdict.
// ---------------------------------------------------------------------------
module sorted_path_name_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spnc_pkg::*;

  localparam int NAME_BYTES     = 64;
  localparam int RANDOM_NAMES   = 7;     // ~2000 bytes with the directed names
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
  localparam int DRAIN_CYCLES   = 10;    // result trails last byte through check stage and output register

  // receiver stall styles
  localparam int RX_ALWAYS  = 0;
  localparam int RX_PATTERN = 1;
  localparam int RX_RANDOM  = 2;

  // random name families
  localparam int GEN_PATH    = 0;
  localparam int GEN_DERIVED = 1;
  localparam int GEN_BROKEN  = 2;
  localparam int GEN_NOISE   = 3;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;

  spnc_in_if  names ();
  spnc_out_if results ();

  sorted_path_name_checker_core #(
    .NAME_BYTES(NAME_BYTES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .names  (names),
    .results(results)
  );

  spnc_verdict_checker #(
    .NAME_BYTES(NAME_BYTES)
  ) verdicts (
    .clk       (clk),
    .rst       (rst),
    .names     (names),
    .results   (results),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // 12 ns clock, starts low so the first edge is clean
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // -------------------------------------------------------------------------
  // Receiver: stall style is re-chosen at random over the run. The pattern style
  // always keeps bits 0 and 8 set so it can never stall for long.
  // -------------------------------------------------------------------------
  int          rx_cycle;
  int          rx_mode;
  logic [15:0] rx_pattern;

  always @(posedge clk) begin
    if (rx_cycle % 128 == 0) begin
      rx_mode    = $urandom_range(RX_ALWAYS, RX_RANDOM);
      rx_pattern = 16'($urandom) | 16'h0101;
    end
    case (rx_mode)
      RX_ALWAYS:  results.ready <= 1'b1;
      RX_PATTERN: results.ready <= rx_pattern[rx_cycle % 16];
      default:    results.ready <= ($urandom_range(0, 3) != 0);
    endcase
    rx_cycle++;
  end

  // -------------------------------------------------------------------------
  // Watchdog: any accepted item on either side resets the count.
  // -------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin
    if ((names.valid && names.ready) || (results.valid && results.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Name sender
  // -------------------------------------------------------------------------
  logic [BYTE_W-1:0] name_buf  [NAME_BYTES];
  logic [BYTE_W-1:0] last_name [NAME_BYTES];  // only to derive related names
  int                burst_left;
  bit                steady;                  // no gaps while set

  // Present one byte and hold it until accepted. A gap, if due, is opened
  // right after the handshake so valid never drops and rises in one step.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic ls);
    names.valid      <= 1'b1;
    names.name_byte  <= b;
    names.list_start <= ls;
    @(posedge clk);
    while (!names.ready) @(posedge clk);
    burst_left--;
    if (!steady && burst_left <= 0) begin
      names.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // list_start only matters on the last byte; toggle it freely elsewhere
  task automatic send_name(input logic ls);
    for (int i = 0; i < NAME_BYTES; i++)
      push_byte(name_buf[i], (i == NAME_BYTES - 1) ? ls : logic'($urandom_range(0, 1)));
    last_name = name_buf;
  endtask

  task automatic set_text(input string s);
    foreach (name_buf[i]) name_buf[i] = CH_NUL;
    for (int i = 0; i < s.len() && i < NAME_BYTES; i++) name_buf[i] = s[i];
  endtask

  task automatic put(input string s, input logic ls);
    set_text(s);
    send_name(ls);
  endtask

  function automatic logic [BYTE_W-1:0] legal_char();
    int r;
    r = $urandom_range(0, 38);
    if (r < 26) return CH_LO_A + BYTE_W'(r);
    if (r < 36) return CH_DIG_0 + BYTE_W'(r - 26);
    if (r == 36) return CH_UNDER;
    if (r == 37) return CH_HYPH;
    return CH_DOT;
  endfunction

  function automatic int term_index();
    for (int i = 0; i < NAME_BYTES; i++)
      if (name_buf[i] == CH_NUL) return i;
    return NAME_BYTES;
  endfunction

  // Well-formed-looking path: segments of legal characters, never a leading
  // or trailing slash. Dot-heavy, so "." and ".." segments still turn up.
  // Most names are short; a quarter reach toward the full length.
  task automatic build_path();
    int n;
    int seg;
    n   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NAME_BYTES - 1)
                                      : $urandom_range(1, 16);
    seg = 0;
    foreach (name_buf[i]) name_buf[i] = CH_NUL;
    for (int i = 0; i < n; i++) begin
      if (seg > 0 && i < n - 1 && $urandom_range(0, 4) == 0) begin
        name_buf[i] = CH_SLASH;
        seg = 0;
      end else begin
        name_buf[i] = ($urandom_range(0, 5) == 0) ? CH_DOT : legal_char();
        seg++;
      end
    end
  endtask

  // Near neighbor of the previous name: equal, one byte nudged, cut short
  // or extended by one character. Hits every order outcome often.
  task automatic build_derived();
    int t;
    int p;
    int pick;
    name_buf = last_name;
    t    = term_index();
    pick = $urandom_range(0, 3);
    if (pick == 1 && t > 0) begin
      p = $urandom_range(0, t - 1);
      name_buf[p] = $urandom_range(0, 1) ? name_buf[p] + 8'd1 : name_buf[p] - 8'd1;
    end else if (pick == 2 && t > 1) begin
      p = $urandom_range(1, t - 1);
      for (int i = p; i < NAME_BYTES; i++) name_buf[i] = CH_NUL;
    end else if (pick == 3 && t < NAME_BYTES - 1) begin
      name_buf[t] = legal_char();
    end
  endtask

  // A path with one defect injected
  task automatic build_broken();
    int t;
    int p;
    build_path();
    t = term_index();
    case ($urandom_range(0, 4))
      0: for (int i = t; i < NAME_BYTES; i++) name_buf[i] = legal_char();  // no terminator
      1: name_buf[$urandom_range(t + 1, NAME_BYTES - 1)] = BYTE_W'($urandom_range(1, 255));
      2: name_buf[$urandom_range(0, t - 1)] = BYTE_W'($urandom_range(1, 255));
      3: begin
        // empty segment: leading, trailing or doubled slash
        p = $urandom_range(0, 2);
        if (p == 0) name_buf[0] = CH_SLASH;
        else if (p == 1 || t < 3) name_buf[t - 1] = CH_SLASH;
        else begin
          p = $urandom_range(0, t - 2);
          name_buf[p]     = CH_SLASH;
          name_buf[p + 1] = CH_SLASH;
        end
      end
      default: foreach (name_buf[i]) name_buf[i] = CH_NUL;  // empty name
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int gen;
    int r;
    rst              <= 1'b1;
    names.valid      <= 1'b0;
    names.name_byte  <= CH_NUL;
    names.list_start <= 1'b0;
    burst_left        = $urandom_range(1, 40);
    steady            = 1'b0;
    foreach (last_name[i]) last_name[i] = CH_NUL;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed names. The empty name goes first: after reset it matches the
    // all-zero history exactly, so it is neither valid nor ascending.
    put("", 1'b0);
    put("a", 1'b0);
    put("a", 1'b0);          // identical to previous: not ascending
    put("ab", 1'b0);
    put("a", 1'b0);          // prefix of previous: less
    put("a", 1'b1);          // list start overrides the equal compare
    put(".", 1'b0);
    put("..", 1'b0);
    put("...", 1'b0);        // three dots is an ordinary segment
    put(".a", 1'b0);
    put("a.", 1'b0);
    put("a/./b", 1'b0);
    put("a/../b", 1'b0);
    put("/a", 1'b0);
    put("a/", 1'b0);
    put("a//b", 1'b0);
    put("az09_-.x/m", 1'b0);
    put("aZ", 1'b0);         // upper case not allowed
    put("a b", 1'b0);

    // longest legal name: terminator in the last byte
    set_text("");
    for (int i = 0; i < NAME_BYTES - 1; i++) name_buf[i] = CH_LO_Z;
    send_name(1'b0);

    // no terminator at all
    for (int i = 0; i < NAME_BYTES; i++) name_buf[i] = CH_DIG_9;
    send_name(1'b0);

    // garbage in the padding
    set_text("abc");
    name_buf[NAME_BYTES - 1] = 8'h80;
    send_name(1'b0);

    // order is unsigned: 0x7f < 0x80 < 0xff
    set_text("");
    name_buf[0] = 8'h7F;
    send_name(1'b0);
    name_buf[0] = 8'h80;
    send_name(1'b0);
    name_buf[0] = 8'hFF;
    send_name(1'b0);

    // Random names: mostly plausible paths and near neighbors of the
    // previous name, the rest defective names and raw byte noise.
    for (int n = 0; n < RANDOM_NAMES; n++) begin
      if ($urandom_range(0, 5) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < 45) gen = GEN_PATH;
      else if (r < 70) gen = GEN_DERIVED;
      else if (r < 90) gen = GEN_BROKEN;
      else gen = GEN_NOISE;
      case (gen)
        GEN_PATH:    build_path();
        GEN_DERIVED: build_derived();
        GEN_BROKEN:  build_broken();
        default:     foreach (name_buf[i]) name_buf[i] = BYTE_W'($urandom_range(0, 255));
      endcase
      send_name(logic'($urandom_range(0, 6) == 0));
    end
    names.valid <= 1'b0;

    // Let the last push reach the checker's pending count, drain, then settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
